FILE: rtl/core/i2cs_pkg.sv
// Shared types, constants and phase tables of the I2C master bit sequencer.
package i2cs_pkg;

	// Field widths
	localparam int CMD_W       = 3;
	localparam int BYTE_W      = 8;
	localparam int TPP_W       = 16;
	localparam int PHASE_W     = 5;
	localparam int MSB_INDEX   = 7;

	// Defaults
	localparam int TICK_COUNT_WIDTH_DEF = 16;
	localparam logic [TPP_W-1:0] TPP_RESET = 16'd100;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_START = 3'd0,
		CMD_STOP  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_READ  = 3'd3,
		CMD_SACK  = 3'd4,
		CMD_WACK  = 3'd5
	} cmd_e_t;

	// Line drive levels of one phase
	typedef struct packed {
		logic scl;
		logic sda;
	} levels_t;

	// Number of line phases in each command
	function automatic logic [PHASE_W-1:0] phase_total(cmd_e_t c);
		logic [PHASE_W-1:0] n;
		unique case (c)
			CMD_START: n = 5'd3;
			CMD_STOP:  n = 5'd2;
			CMD_WRITE: n = 5'd25;
			CMD_READ:  n = 5'd16;
			CMD_SACK:  n = 5'd4;
			default:   n = 5'd2;
		endcase
		return n;
	endfunction

endpackage

FILE: rtl/core/i2cs_tick_if.sv
// Input channel: one bus tick with an optional command and the sampled SDA level.
interface i2cs_tick_if;
	import i2cs_pkg::*;

	logic              valid;
	logic              ready;
	logic              cmd_valid;
	logic [CMD_W-1:0]  cmd;
	logic [BYTE_W-1:0] tx_byte;
	logic              ack_level;
	logic              sda_in;

	modport source (output valid, cmd_valid, cmd, tx_byte, ack_level, sda_in, input ready);
	modport sink   (input valid, cmd_valid, cmd, tx_byte, ack_level, sda_in, output ready);
endinterface

FILE: rtl/core/i2cs_result_if.sv
// Output channel: line levels and status of one bus tick.
interface i2cs_result_if;
	import i2cs_pkg::*;

	logic              valid;
	logic              ready;
	logic              scl_level;
	logic              sda_level;
	logic              busy_res;
	logic              done_res;
	logic [BYTE_W-1:0] rx_byte;
	logic              ack_seen;

	modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte, ack_seen,
		input ready);
	modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte, ack_seen,
		output ready);
endinterface

FILE: rtl/core/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: tick register, sequencer state, result register.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+--------------------------------------------------
//  tick      | in  | valid/ready   | cmd_valid, cmd, tx_byte, ack_level, sda_in
//  result    | out | valid/ready   | scl_level, sda_level, busy_res, done_res, rx_byte,
//            |     |               | ack_seen
//  cfg       | in  | cfg_wr_en     | cfg_wr_data (ticks_per_phase)
//
// One tick per cycle while the result side is not stalled; a tick passes the tick register,
// then the result register. The sequencer state advances when the tick register moves on.
// Reset returns the lines to released, the sequencer to idle and ticks_per_phase to 100.
// A stalled result holds both stages; tick ready falls only when both are full.
module i2c_master_bit_sequencer #(
	parameter int TICK_COUNT_WIDTH = i2cs_pkg::TICK_COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [i2cs_pkg::TPP_W-1:0]  cfg_wr_data,
	i2cs_tick_if.sink                   tick,
	i2cs_result_if.source               result
);
	import i2cs_pkg::*;

	localparam int LEN_W = ((TICK_COUNT_WIDTH > TPP_W) ? TICK_COUNT_WIDTH : TPP_W) + 1;

	// Configuration
	logic [TPP_W-1:0] tpp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpp_q <= TPP_RESET;
		end else if (cfg_wr_en) begin
			tpp_q <= cfg_wr_data;
		end
	end

	// Pipeline flow control
	logic valid_s1, valid_s2, advance;

	assign advance    = !valid_s2 || result.ready;
	assign tick.ready = !valid_s1 || advance;

	// Tick register
	logic              cmd_valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [BYTE_W-1:0] tx_byte_s1;
	logic              ack_level_s1;
	logic              sda_in_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			cmd_valid_s1 <= tick.cmd_valid;
			cmd_s1       <= tick.cmd;
			tx_byte_s1   <= tick.tx_byte;
			ack_level_s1 <= tick.ack_level;
			sda_in_s1    <= tick.sda_in;
		end
	end

	// Sequencer state
	cmd_e_t                      cmd_q;
	logic                        busy_q;
	logic [PHASE_W-1:0]          phase_q;
	logic [TICK_COUNT_WIDTH-1:0] tick_q;
	logic [BYTE_W-1:0]           shift_q;
	logic                        scl_q, sda_q, ack_q;
	logic [BYTE_W-1:0]           rx_hold_q;

	// Values for this tick, after a possible command start
	logic                        start_cmd;
	cmd_e_t                      cmd_eff;
	logic                        busy_eff;
	logic [PHASE_W-1:0]          phase_eff;
	logic [TICK_COUNT_WIDTH-1:0] tick_eff;
	logic [BYTE_W-1:0]           shift_eff;
	levels_t                     lv;
	logic [LEN_W-1:0]            len_raw, len_cap, len_eff;
	logic                        last_tick, last_phase;

	// Next-state values
	cmd_e_t                      cmd_d;
	logic                        busy_d;
	logic [PHASE_W-1:0]          phase_d;
	logic [TICK_COUNT_WIDTH-1:0] tick_d;
	logic [BYTE_W-1:0]           shift_d;
	logic                        scl_d, sda_d, ack_d, done_d;
	logic [BYTE_W-1:0]           rx_hold_d;

	// Command start and effective state
	always_comb begin
		start_cmd = !busy_q && cmd_valid_s1 && (cmd_s1 <= CMD_WACK);
		cmd_eff   = start_cmd ? cmd_e_t'(cmd_s1) : cmd_q;
		busy_eff  = busy_q || start_cmd;
		phase_eff = start_cmd ? '0 : phase_q;
		tick_eff  = start_cmd ? '0 : tick_q;
		if (start_cmd) begin
			if (cmd_e_t'(cmd_s1) == CMD_WRITE) begin
				shift_eff = tx_byte_s1;
			end else if (cmd_e_t'(cmd_s1) == CMD_SACK) begin
				shift_eff = {{(BYTE_W-1){1'b0}}, ack_level_s1};
			end else begin
				shift_eff = '0;
			end
		end else begin
			shift_eff = shift_q;
		end
	end

	i2cs_phase_gen u_phase_gen (
		.cmd    (cmd_eff),
		.phase  (phase_eff),
		.shift  (shift_eff),
		.levels (lv)
	);

	// Phase length: zero acts as one, capped by the counter range
	always_comb begin
		len_raw = LEN_W'(tpp_q);
		len_cap = LEN_W'(1) << TICK_COUNT_WIDTH;
		if (tpp_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_raw > len_cap) begin
			len_eff = len_cap;
		end else begin
			len_eff = len_raw;
		end
		last_tick  = (LEN_W'(tick_eff) + LEN_W'(1)) >= len_eff;
		last_phase = ({1'b0, phase_eff} + 6'd1) >= {1'b0, phase_total(cmd_eff)};
	end

	// Next state
	always_comb begin
		cmd_d     = cmd_eff;
		busy_d    = busy_eff;
		phase_d   = phase_eff;
		tick_d    = tick_eff;
		shift_d   = shift_eff;
		scl_d     = scl_q;
		sda_d     = sda_q;
		ack_d     = ack_q;
		rx_hold_d = rx_hold_q;
		done_d    = 1'b0;
		if (busy_eff) begin
			scl_d = lv.scl;
			sda_d = lv.sda;
			if (last_tick) begin
				if (cmd_eff == CMD_READ && !phase_eff[0]) begin
					shift_d = {shift_eff[BYTE_W-2:0], sda_in_s1};
				end
				if (cmd_eff == CMD_WACK && phase_eff == '0) begin
					ack_d = sda_in_s1;
				end
				if (last_phase) begin
					done_d  = 1'b1;
					busy_d  = 1'b0;
					phase_d = '0;
					if (cmd_eff == CMD_READ) begin
						rx_hold_d = shift_d;
					end
				end else begin
					phase_d = phase_eff + PHASE_W'(1);
				end
				tick_d = '0;
			end else begin
				tick_d = tick_eff + TICK_COUNT_WIDTH'(1);
			end
		end
	end

	wire step = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= CMD_START;
			busy_q    <= 1'b0;
			phase_q   <= '0;
			tick_q    <= '0;
			shift_q   <= '0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			ack_q     <= 1'b0;
			rx_hold_q <= '0;
		end else if (step) begin
			cmd_q     <= cmd_d;
			busy_q    <= busy_d;
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			shift_q   <= shift_d;
			scl_q     <= scl_d;
			sda_q     <= sda_d;
			ack_q     <= ack_d;
			rx_hold_q <= rx_hold_d;
		end
	end

	// Result register
	logic              scl_s2, sda_s2, busy_s2, done_s2, ack_s2;
	logic [BYTE_W-1:0] rx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			scl_s2  <= scl_d;
			sda_s2  <= sda_d;
			busy_s2 <= busy_eff;
			done_s2 <= done_d;
			rx_s2   <= rx_hold_d;
			ack_s2  <= ack_d;
		end
	end

	assign result.valid     = valid_s2;
	assign result.scl_level = scl_s2;
	assign result.sda_level = sda_s2;
	assign result.busy_res  = busy_s2;
	assign result.done_res  = done_s2;
	assign result.rx_byte   = rx_s2;
	assign result.ack_seen  = ack_s2;

	// Checks
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && done_s2) |-> busy_s2)
		else $error("done without busy");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (phase_q < phase_total(cmd_q)))
		else $error("phase index beyond command length");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (phase_q == '0 && tick_q == '0))
		else $error("idle with live phase or tick count");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && done_d) |=> !busy_q)
		else $error("sequencer still busy after done");

endmodule

FILE: rtl/core/i2cs_phase_gen.sv
// Decodes the SCL/SDA levels of one phase of the active command.
module i2cs_phase_gen (
	input  i2cs_pkg::cmd_e_t               cmd,
	input  logic [i2cs_pkg::PHASE_W-1:0]   phase,
	input  logic [i2cs_pkg::BYTE_W-1:0]    shift,
	output i2cs_pkg::levels_t              levels
);
	import i2cs_pkg::*;

	// Write byte: after the lead phase, groups of three (low, high, low) per bit
	logic [PHASE_W-1:0] wr_q;
	logic [2:0]         wr_bit;
	logic               wr_high;

	always_comb begin
		wr_q    = phase - PHASE_W'(1);
		wr_bit  = 3'(MSB_INDEX);
		wr_high = 1'b0;
		for (int k = 0; k < 8; k++) begin
			if (wr_q >= PHASE_W'(3 * k) && wr_q < PHASE_W'(3 * k + 3)) begin
				wr_bit  = 3'(MSB_INDEX - k);
				wr_high = (wr_q == PHASE_W'(3 * k + 1));
			end
		end
	end

	// Level table per command
	always_comb begin
		unique case (cmd)
			CMD_START: begin
				levels.scl = (phase < 5'd2);
				levels.sda = (phase == 5'd0);
			end
			CMD_STOP: begin
				levels.scl = 1'b1;
				levels.sda = (phase != 5'd0);
			end
			CMD_WRITE: begin
				if (phase == 5'd0) begin
					levels.scl = 1'b0;
					levels.sda = 1'b0;
				end else begin
					levels.scl = wr_high;
					levels.sda = shift[wr_bit];
				end
			end
			CMD_READ: begin
				levels.scl = ~phase[0];
				levels.sda = 1'b1;
			end
			CMD_SACK: begin
				levels.scl = (phase == 5'd2);
				levels.sda = (phase == 5'd0) ? 1'b0 : shift[0];
			end
			default: begin
				levels.scl = (phase == 5'd0);
				levels.sda = 1'b1;
			end
		endcase
	end

endmodule

FILE: tb/tb_top.sv
// Testbench for the I2C master bit sequencer: tick driver, line-level predictor and result checks.
`timescale 1ns / 1ps

module tb_top;
	import i2cs_pkg::*;

	// Command codes the block must ignore
	localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;

	// How the SDA pin is fed during a command
	localparam int SDA_LOW  = 0;
	localparam int SDA_HIGH = 1;
	localparam int SDA_RAND = 2;

	localparam int CYCLE_LIMIT = 50_000;
	localparam int DRAIN_CYCLES = 4;

	typedef struct packed {
		logic              cmd_valid;
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] tx_byte;
		logic              ack_level;
		logic              sda_in;
	} tick_item_t;

	typedef struct packed {
		logic              scl;
		logic              sda;
		logic              busy;
		logic              done;
		logic [BYTE_W-1:0] rx;
		logic              ack;
	} line_state_t;

	// Predicts the line levels and status of every tick and checks the block against them
	class line_scoreboard;
		logic [TPP_W-1:0]  tpp;
		cmd_e_t            act;
		logic              busy;
		int unsigned       phase;
		int unsigned       cnt;
		logic [BYTE_W-1:0] shreg;
		logic              scl;
		logic              sda;
		logic              ack;
		logic [BYTE_W-1:0] rx_hold;
		line_state_t       want_q[$];
		int                errors;

		function new();
			tpp     = TPP_RESET;
			act     = CMD_START;
			busy    = 1'b0;
			phase   = 0;
			cnt     = 0;
			shreg   = '0;
			scl     = 1'b1;
			sda     = 1'b1;
			ack     = 1'b0;
			rx_hold = '0;
			errors  = 0;
		endfunction

		function int unsigned n_phases(cmd_e_t c);
			case (c)
				CMD_START: return 3;
				CMD_STOP:  return 2;
				CMD_WRITE: return 25;
				CMD_READ:  return 16;
				CMD_SACK:  return 4;
				default:   return 2;
			endcase
		endfunction

		// Levels driven in the current phase of the active command
		function void drive_levels();
			int unsigned bitpos;
			case (act)
				CMD_START: begin
					scl = (phase < 2);
					sda = (phase == 0);
				end
				CMD_STOP: begin
					scl = 1'b1;
					sda = (phase != 0);
				end
				CMD_WRITE: begin
					if (phase == 0) begin
						scl = 1'b0;
						sda = 1'b0;
					end else begin
						bitpos = MSB_INDEX - ((phase - 1) / 3) % 8;
						sda = shreg[bitpos];
						scl = ((phase - 1) % 3 == 1);
					end
				end
				CMD_READ: begin
					sda = 1'b1;
					scl = (phase % 2 == 0);
				end
				CMD_SACK: begin
					sda = (phase == 0) ? 1'b0 : shreg[0];
					scl = (phase == 2);
				end
				default: begin
					sda = 1'b1;
					scl = (phase == 0);
				end
			endcase
		endfunction

		// One accepted tick: advance the sequencer and queue the expected result
		function void note_tick(tick_item_t t);
			int unsigned len;
			line_state_t r;
			len = (tpp == 0) ? 1 : tpp;
			r.done = 1'b0;
			if (!busy && t.cmd_valid && t.cmd <= CMD_WACK) begin
				act   = cmd_e_t'(t.cmd);
				busy  = 1'b1;
				phase = 0;
				cnt   = 0;
				case (act)
					CMD_WRITE: shreg = t.tx_byte;
					CMD_SACK:  shreg = {7'd0, t.ack_level};
					default:   shreg = '0;
				endcase
			end
			r.busy = busy;
			if (busy) begin
				drive_levels();
				if (cnt + 1 >= len) begin
					// sample points sit at the end of SCL-high phases
					if (act == CMD_READ && phase % 2 == 0)
						shreg = {shreg[BYTE_W-2:0], t.sda_in};
					if (act == CMD_WACK && phase == 0)
						ack = t.sda_in;
					if (phase + 1 >= n_phases(act)) begin
						r.done = 1'b1;
						busy   = 1'b0;
						if (act == CMD_READ)
							rx_hold = shreg;
						phase = 0;
					end else begin
						phase++;
					end
					cnt = 0;
				end else begin
					cnt++;
				end
			end
			r.scl = scl;
			r.sda = sda;
			r.rx  = rx_hold;
			r.ack = ack;
			want_q.push_back(r);
		endfunction

		function void field_check(string name, int unsigned e, int unsigned a);
			if (e != a) begin
				$error("%s: expected %0h, got %0h", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(line_state_t got);
			line_state_t w;
			if (want_q.size() == 0) begin
				$error("result transaction with no expected tick pending");
				errors++;
				return;
			end
			w = want_q.pop_front();
			field_check("scl_level", w.scl, got.scl);
			field_check("sda_level", w.sda, got.sda);
			field_check("busy_res", w.busy, got.busy);
			field_check("done_res", w.done, got.done);
			field_check("rx_byte", w.rx, got.rx);
			field_check("ack_seen", w.ack, got.ack);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [TPP_W-1:0]    cfg_wr_data;
	bit                  idle_on;
	int                  stall_left;
	int                  cycles;
	line_scoreboard      sb = new();

	i2cs_tick_if   tick_ch ();
	i2cs_result_if res_ch ();

	i2c_master_bit_sequencer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.tick        (tick_ch),
		.result      (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// Result side: random stall bursts while idling is enabled
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = int'($urandom_range(0, 7));
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Result monitor
	always @(posedge clk) begin : mon
		line_state_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.scl  = res_ch.scl_level;
			got.sda  = res_ch.sda_level;
			got.busy = res_ch.busy_res;
			got.done = res_ch.done_res;
			got.rx   = res_ch.rx_byte;
			got.ack  = res_ch.ack_seen;
			sb.check_result(got);
		end
	end

	function automatic tick_item_t make_tick(logic cv, logic [CMD_W-1:0] c,
			logic [BYTE_W-1:0] txb, logic al, logic sdi);
		tick_item_t t;
		t.cmd_valid = cv;
		t.cmd       = c;
		t.tx_byte   = txb;
		t.ack_level = al;
		t.sda_in    = sdi;
		return t;
	endfunction

	function automatic logic pick_sda(int mode);
		if (mode == SDA_RAND)
			return 1'($urandom_range(0, 1));
		return (mode == SDA_HIGH);
	endfunction

	// Drive one tick transaction and note it once accepted
	task automatic send_tick(tick_item_t t);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 8)) begin
				@(negedge clk);
				tick_ch.valid <= 1'b0;
			end
		end
		@(negedge clk);
		tick_ch.valid     <= 1'b1;
		tick_ch.cmd_valid <= t.cmd_valid;
		tick_ch.cmd       <= t.cmd;
		tick_ch.tx_byte   <= t.tx_byte;
		tick_ch.ack_level <= t.ack_level;
		tick_ch.sda_in    <= t.sda_in;
		do @(posedge clk); while (!tick_ch.ready);
		sb.note_tick(t);
	endtask

	// Offer a command on an idle tick, then tick until the sequence ends.
	// Ticks during the sequence carry random commands that must be ignored.
	task automatic run_cmd(logic [CMD_W-1:0] c, logic [BYTE_W-1:0] txb, logic al, int mode);
		send_tick(make_tick(1'b1, c, txb, al, pick_sda(mode)));
		while (sb.busy)
			send_tick(make_tick($urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)),
				8'($urandom), 1'($urandom_range(0, 1)), pick_sda(mode)));
	endtask

	// Stop sending and wait for every expected result, plus pipeline slack
	task automatic drain();
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		while (sb.want_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_tpp(logic [TPP_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		sb.tpp = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random commands with short gaps; a few undefined codes mixed in
	task automatic run_random(int n);
		int r;
		int mode;
		logic [CMD_W-1:0] c;
		repeat (n) begin
			repeat ($urandom_range(0, 2))
				send_tick(make_tick(1'($urandom_range(0, 1)),
					CMD_BAD_LO | 3'($urandom_range(0, 1)), 8'($urandom),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
			r = int'($urandom_range(0, 19));
			c = (r < 18) ? 3'(r % 6) : ((r % 2) ? CMD_BAD_HI : CMD_BAD_LO);
			mode = ($urandom_range(0, 5) < 4) ? SDA_RAND :
				int'($urandom_range(SDA_LOW, SDA_HIGH));
			run_cmd(c, 8'($urandom), 1'($urandom_range(0, 1)), mode);
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = '0;
		tick_ch.valid     = 1'b0;
		tick_ch.cmd_valid = 1'b0;
		tick_ch.cmd       = CMD_START;
		tick_ch.tx_byte   = '0;
		tick_ch.ack_level = 1'b0;
		tick_ch.sda_in    = 1'b1;
		idle_on           = 1'b1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Reset phase length; an idle tick first shows the released lines
		send_tick(make_tick(1'b0, CMD_START, 8'h00, 1'b0, 1'b1));
		run_cmd(CMD_WACK, 8'h00, 1'b0, SDA_RAND);

		// Directed: every command and both extremes of the data fields
		set_tpp(16'd1);
		run_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND);
		run_cmd(CMD_WRITE, 8'hFF, 1'b1, SDA_RAND);
		run_cmd(CMD_WRITE, 8'h00, 1'b0, SDA_RAND);
		run_cmd(CMD_READ, 8'h00, 1'b0, SDA_HIGH);
		run_cmd(CMD_READ, 8'hFF, 1'b1, SDA_LOW);
		run_cmd(CMD_READ, 8'h00, 1'b0, SDA_RAND);
		run_cmd(CMD_SACK, 8'h00, 1'b0, SDA_RAND);
		run_cmd(CMD_SACK, 8'hFF, 1'b1, SDA_RAND);
		run_cmd(CMD_WACK, 8'h00, 1'b0, SDA_HIGH);
		run_cmd(CMD_WACK, 8'h00, 1'b0, SDA_LOW);
		run_cmd(CMD_BAD_LO, 8'hFF, 1'b1, SDA_RAND);
		run_cmd(CMD_BAD_HI, 8'hFF, 1'b1, SDA_RAND);
		run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND);

		// Zero phase length behaves as one tick
		set_tpp(16'd0);
		run_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND);
		run_cmd(CMD_WRITE, 8'($urandom), 1'b0, SDA_RAND);
		run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND);

		// Random traffic at a short phase length
		set_tpp(16'd1);
		run_random(3);

		// Last part runs with no idling on either side
		set_tpp(16'd2);
		idle_on = 1'b0;
		run_random(2);

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

FILE: i2c_master_bit_sequencer.f
rtl/core/i2cs_pkg.sv
rtl/core/i2cs_tick_if.sv
rtl/core/i2cs_result_if.sv
rtl/core/i2cs_phase_gen.sv
rtl/core/i2c_master_bit_sequencer.sv
tb/tb_top.sv
